// ===== hw/rtl/multi_queue_manager_with_join_macros.svh =====
// Assertion macros used by the queue manager datapath.
`ifndef MULTI_QUEUE_MANAGER_WITH_JOIN_MACROS_SVH
`define MULTI_QUEUE_MANAGER_WITH_JOIN_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MQJ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MQJ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/mqj_pkg.sv =====
// Package with types and constants of the multi-queue manager.
package mqj_pkg;

  localparam int unsigned QueuesDefault = 128;
  localparam int unsigned NodesDefault  = 1024;
  localparam int unsigned IdBitsDefault = 16;
  localparam int unsigned QselBits      = 7;
  localparam int unsigned IdPortBits    = 16;
  localparam logic [7:0]  ActiveReset   = 8'd128;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_LEAVE = 2'd1,
    OP_JOIN  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_BADQ  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    PATH_NONE,
    PATH_ADD,
    PATH_LEAVE,
    PATH_JOIN
  } path_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DEST,
    S_NODE,
    S_EXEC,
    S_DONE
  } state_e;

  typedef struct packed {
    logic capture;
    logic check;
    logic rd_dst;
    logic rd_node;
    logic exec;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    path_e path;
    logic  out_free;
  } stat_t;

endpackage

// ===== hw/rtl/mqj_ctrl.sv =====
// Controller state machine that sequences one operation at a time.
module mqj_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mqj_pkg::stat_t     stat_i,
  output mqj_pkg::cmd_t      cmd_o
);

  mqj_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mqj_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      mqj_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = mqj_pkg::S_CHECK;
        end
      end
      mqj_pkg::S_CHECK: begin
        cmd_o.check = 1'b1;
        unique case (stat_i.path)
          mqj_pkg::PATH_ADD:   state_d = mqj_pkg::S_EXEC;
          mqj_pkg::PATH_LEAVE: state_d = mqj_pkg::S_NODE;
          mqj_pkg::PATH_JOIN:  state_d = mqj_pkg::S_DEST;
          default:             state_d = mqj_pkg::S_DONE;
        endcase
      end
      mqj_pkg::S_DEST: begin
        cmd_o.rd_dst = 1'b1;
        state_d      = mqj_pkg::S_EXEC;
      end
      mqj_pkg::S_NODE: begin
        cmd_o.rd_node = 1'b1;
        state_d       = mqj_pkg::S_EXEC;
      end
      mqj_pkg::S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = mqj_pkg::S_DONE;
      end
      mqj_pkg::S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = mqj_pkg::S_IDLE;
        end
      end
      default: state_d = mqj_pkg::S_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/mqj_datapath.sv =====
// Datapath with queue tables, node pool memories, free list and result register.
`include "multi_queue_manager_with_join_macros.svh"

module mqj_datapath #(
  parameter int unsigned QUEUES  = mqj_pkg::QueuesDefault,
  parameter int unsigned NODES   = mqj_pkg::NodesDefault,
  parameter int unsigned ID_BITS = mqj_pkg::IdBitsDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [7:0]                       active_i,
  input  logic [1:0]                       operation_i,
  input  logic [mqj_pkg::QselBits-1:0]     queue_sel_i,
  input  logic [mqj_pkg::QselBits-1:0]     dest_queue_i,
  input  logic [mqj_pkg::IdPortBits-1:0]   entry_id_i,
  input  mqj_pkg::cmd_t                    cmd_i,
  output mqj_pkg::stat_t                   stat_o,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [1:0]                       status_o,
  output logic [mqj_pkg::IdPortBits-1:0]   removed_id_o
);

  localparam int unsigned QW  = $clog2(QUEUES);
  localparam int unsigned NW  = $clog2(NODES);
  localparam int unsigned QXW = QW + mqj_pkg::QselBits;

  logic [1:0]                     op_q;
  logic [mqj_pkg::QselBits-1:0]   q_q, d_q;
  logic [ID_BITS-1:0]             id_q;

  logic [NW-1:0] head_mem [QUEUES];
  logic [NW-1:0] tail_mem [QUEUES];
  logic [NW-1:0] next_mem [NODES];
  logic [ID_BITS-1:0] value_mem [NODES];
  logic [QUEUES-1:0] nonempty_q;

  logic [NW-1:0] head_rd_q, tail_rd_q, next_rd_q, tail_src_q;
  logic [ID_BITS-1:0] value_rd_q;

  logic [NW-1:0] free_head_q;
  logic [NW:0]   rec_cnt_q, fresh_q;

  mqj_pkg::path_e path_q, path_c;
  mqj_pkg::status_e status_c;
  logic [1:0]  res_status_q;
  logic [mqj_pkg::IdPortBits-1:0] res_removed_q;
  logic        out_valid_q;
  logic [1:0]  out_status_q;
  logic [mqj_pkg::IdPortBits-1:0] out_removed_q;

  logic [QXW-1:0] q_ext, d_ext;
  logic [QW-1:0]  qi, di;
  logic q_ok, d_ok, pool_full;
  logic [NW-1:0] new_node;

  assign q_ext     = QXW'(q_q);
  assign d_ext     = QXW'(d_q);
  assign qi        = q_ext[QW-1:0];
  assign di        = d_ext[QW-1:0];
  assign q_ok      = ({1'b0, q_q} < active_i) && (32'(q_q) < QUEUES);
  assign d_ok      = ({1'b0, d_q} < active_i) && (32'(d_q) < QUEUES);
  assign pool_full = (rec_cnt_q == '0) && (fresh_q == (NW+1)'(NODES));
  assign new_node  = (rec_cnt_q != '0) ? free_head_q : fresh_q[NW-1:0];

  always_comb begin
    status_c = mqj_pkg::ST_OK;
    path_c   = mqj_pkg::PATH_NONE;
    unique case (mqj_pkg::op_e'(op_q))
      mqj_pkg::OP_ADD: begin
        if (!q_ok) begin
          status_c = mqj_pkg::ST_BADQ;
        end else if (pool_full) begin
          status_c = mqj_pkg::ST_FULL;
        end else begin
          path_c = mqj_pkg::PATH_ADD;
        end
      end
      mqj_pkg::OP_LEAVE: begin
        if (!q_ok) begin
          status_c = mqj_pkg::ST_BADQ;
        end else if (!nonempty_q[qi]) begin
          status_c = mqj_pkg::ST_EMPTY;
        end else begin
          path_c = mqj_pkg::PATH_LEAVE;
        end
      end
      mqj_pkg::OP_JOIN: begin
        if (!(q_ok && d_ok)) begin
          status_c = mqj_pkg::ST_BADQ;
        end else if ((q_q != d_q) && nonempty_q[qi]) begin
          path_c = mqj_pkg::PATH_JOIN;
        end
      end
      default: path_c = mqj_pkg::PATH_NONE;
    endcase
  end

  assign stat_o.path     = path_c;
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q <= operation_i;
      q_q  <= queue_sel_i;
      d_q  <= dest_queue_i;
      id_q <= ID_BITS'(entry_id_i);
    end
    if (cmd_i.check) begin
      path_q        <= path_c;
      res_status_q  <= status_c;
      res_removed_q <= '0;
    end
    if (cmd_i.exec && (path_q == mqj_pkg::PATH_LEAVE)) begin
      res_removed_q <= mqj_pkg::IdPortBits'(value_rd_q);
    end
    if (cmd_i.load_out) begin
      out_status_q  <= res_status_q;
      out_removed_q <= res_removed_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.check) begin
      head_rd_q <= head_mem[qi];
      tail_rd_q <= tail_mem[qi];
      next_rd_q <= next_mem[free_head_q];
    end
    if (cmd_i.rd_dst) begin
      tail_src_q <= tail_rd_q;
      tail_rd_q  <= tail_mem[di];
    end
    if (cmd_i.rd_node) begin
      next_rd_q  <= next_mem[head_rd_q];
      value_rd_q <= value_mem[head_rd_q];
    end
    if (cmd_i.exec) begin
      unique case (path_q)
        mqj_pkg::PATH_ADD: begin
          value_mem[new_node] <= id_q;
          if (nonempty_q[qi]) begin
            next_mem[tail_rd_q] <= new_node;
          end else begin
            head_mem[qi] <= new_node;
          end
          tail_mem[qi] <= new_node;
        end
        mqj_pkg::PATH_LEAVE: begin
          next_mem[head_rd_q] <= free_head_q;
          if (head_rd_q != tail_rd_q) begin
            head_mem[qi] <= next_rd_q;
          end
        end
        mqj_pkg::PATH_JOIN: begin
          if (nonempty_q[di]) begin
            next_mem[tail_rd_q] <= head_rd_q;
          end else begin
            head_mem[di] <= head_rd_q;
          end
          tail_mem[di] <= tail_src_q;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nonempty_q  <= '0;
      free_head_q <= '0;
      rec_cnt_q   <= '0;
      fresh_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.exec) begin
        unique case (path_q)
          mqj_pkg::PATH_ADD: begin
            nonempty_q[qi] <= 1'b1;
            if (rec_cnt_q != '0) begin
              free_head_q <= next_rd_q;
              rec_cnt_q   <= rec_cnt_q - 1'b1;
            end else begin
              fresh_q <= fresh_q + 1'b1;
            end
          end
          mqj_pkg::PATH_LEAVE: begin
            if (head_rd_q == tail_rd_q) begin
              nonempty_q[qi] <= 1'b0;
            end
            free_head_q <= head_rd_q;
            rec_cnt_q   <= rec_cnt_q + 1'b1;
          end
          mqj_pkg::PATH_JOIN: begin
            nonempty_q[di] <= 1'b1;
            nonempty_q[qi] <= 1'b0;
          end
          default: ;
        endcase
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign removed_id_o = out_removed_q;

  `MQJ_ASSERT_IMP(a_rec_le_fresh, 1'b1, rec_cnt_q <= fresh_q, "recycled count exceeds allocated")
  `MQJ_ASSERT_IMP(a_add_not_full, cmd_i.exec && (path_q == mqj_pkg::PATH_ADD), !pool_full,
                  "add executed on a full pool")
  `MQJ_ASSERT_IMP(a_leave_nonempty, cmd_i.exec && (path_q == mqj_pkg::PATH_LEAVE),
                  nonempty_q[qi], "leave executed on an empty queue")
  `MQJ_ASSERT_NXT(a_load_valid, cmd_i.load_out, out_valid_q, "result not presented after load")

endmodule

// ===== hw/rtl/multi_queue_manager_with_join.sv =====
// Top level of the linked-list multi-queue manager with join.
//
// Channel   Direction  Handshake            Payload
// input     in         in_valid_i/in_stall_o operation_i queue_sel_i dest_queue_i entry_id_i
// result    out        out_valid_o/out_stall_i status_o removed_id_o
// config    in         APB psel/penable     paddr pwdata prdata (active_queues at 0)
//
// One operation is in flight at a time. The check state reads the queue tables;
// leave then reads the node pool and join the destination tail, before the single
// write state of add, leave and join. Rejected and no-op items skip to done.
// A result waits in an output register while the next item is taken in.
// Reset empties every queue and returns the whole pool to the free list at once;
// there is no clearing pass.
// A stalled result holds the controller in its last state until the transfer.
module multi_queue_manager_with_join #(
  parameter int unsigned QUEUES  = mqj_pkg::QueuesDefault,
  parameter int unsigned NODES   = mqj_pkg::NodesDefault,
  parameter int unsigned ID_BITS = mqj_pkg::IdBitsDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      operation_i,
  input  logic [mqj_pkg::QselBits-1:0]    queue_sel_i,
  input  logic [mqj_pkg::QselBits-1:0]    dest_queue_i,
  input  logic [mqj_pkg::IdPortBits-1:0]  entry_id_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [1:0]                      status_o,
  output logic [mqj_pkg::IdPortBits-1:0]  removed_id_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [2:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  logic [7:0] active_q;
  mqj_pkg::cmd_t  cmd;
  mqj_pkg::stat_t stat;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {24'd0, active_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= mqj_pkg::ActiveReset;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      active_q <= pwdata[7:0];
    end
  end

  mqj_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mqj_datapath #(
    .QUEUES  (QUEUES),
    .NODES   (NODES),
    .ID_BITS (ID_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .active_i     (active_q),
    .operation_i  (operation_i),
    .queue_sel_i  (queue_sel_i),
    .dest_queue_i (dest_queue_i),
    .entry_id_i   (entry_id_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .removed_id_o (removed_id_o)
  );

endmodule
